>>> hw/rtl/itoa_pkg.sv
// shared types, constants, microprogram and digit character function for the integer to ascii unit
// no dependencies
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W = 8;
  localparam int CHAR_W = 7;
  localparam int DIGIT_W = 4;
  localparam int BITS_PER_STEP = 4;
  localparam int STEP_W = 3;

  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] ST_DIV = 3'd2;
  localparam logic [STEP_W-1:0] ST_STORE = 3'd3;
  localparam logic [STEP_W-1:0] ST_SIGN = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT = 3'd5;
  localparam logic [STEP_W-1:0] ST_TERM = 3'd6;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_DIV = 3'd2;
  localparam logic [2:0] OP_STORE = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_SIGN = 2'd1;
  localparam logic [1:0] EM_DIGIT = 2'd2;
  localparam logic [1:0] EM_NUL = 2'd3;

  localparam logic [2:0] CD_ALWAYS = 3'd0;
  localparam logic [2:0] CD_NO_START = 3'd1;
  localparam logic [2:0] CD_BAD_RADIX = 3'd2;
  localparam logic [2:0] CD_DIV_MORE = 3'd3;
  localparam logic [2:0] CD_Q_NONZERO = 3'd4;
  localparam logic [2:0] CD_CNT_NONZERO = 3'd5;

  typedef struct packed {
    logic busy;
    logic [2:0] op;
    logic [1:0] emit;
    logic [2:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic bad_radix;
    logic div_more;
    logic q_nonzero;
    logic cnt_nonzero;
  } stat_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{busy: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_ALWAYS, target: ST_IDLE};
    unique case (step)
      ST_IDLE: w = '{1'b0, OP_NONE, EM_NONE, CD_NO_START, ST_IDLE};
      ST_CHECK: w = '{1'b1, OP_LOAD, EM_NONE, CD_BAD_RADIX, ST_TERM};
      ST_DIV: w = '{1'b1, OP_DIV, EM_NONE, CD_DIV_MORE, ST_DIV};
      ST_STORE: w = '{1'b1, OP_STORE, EM_NONE, CD_Q_NONZERO, ST_DIV};
      ST_SIGN: w = '{1'b1, OP_READ, EM_SIGN, CD_ALWAYS, ST_EMIT};
      ST_EMIT: w = '{1'b1, OP_READ, EM_DIGIT, CD_CNT_NONZERO, ST_EMIT};
      ST_TERM: w = '{1'b1, OP_NONE, EM_NUL, CD_ALWAYS, ST_IDLE};
      default: w = '{1'b0, OP_NONE, EM_NONE, CD_ALWAYS, ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/itoa_seq.sv
// microprogram sequencer: step counter and conditional jumps over the control store
// depends on itoa_pkg
module itoa_seq
  import itoa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              jump;

  assign ctrl = ucode(step);

  always_comb begin
    unique case (ctrl.cond)
      CD_ALWAYS: jump = 1'b1;
      CD_NO_START: jump = !start;
      CD_BAD_RADIX: jump = stat.bad_radix;
      CD_DIV_MORE: jump = stat.div_more;
      CD_Q_NONZERO: jump = stat.q_nonzero;
      CD_CNT_NONZERO: jump = stat.cnt_nonzero;
      default: jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hw/rtl/itoa_dp.sv
// datapath: operand registers, four-bit-per-cycle small divisor divider, digit buffer, output mux
// depends on itoa_pkg
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]       radix,
  input  ctrl_t                    ctrl,
  output stat_t                    stat,
  output logic                     strobe,
  output logic [CHAR_W-1:0]        character,
  output logic                     last
);

  localparam int DIV_STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int QW = DIV_STEPS * BITS_PER_STEP;
  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int ITW = $clog2(DIV_STEPS);

  logic [VALUE_WIDTH-1:0] val_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [QW-1:0]          quotient;
  logic [DIGIT_W-1:0]     rem;
  logic [ITW-1:0]         iter;
  logic [CW-1:0]          count;
  logic                   neg;
  logic [DIGIT_W-1:0]     rdata;
  logic [DIGIT_W-1:0]     digit_buffer [VALUE_WIDTH];

  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic [QW-1:0]          q_next;
  logic [DIGIT_W-1:0]     rem_next;
  logic [CW-1:0]          cnt_dec;

  assign neg_in = (radix_r == RADIX_DEC) && val_r[VALUE_WIDTH-1];
  assign mag = neg_in ? (~val_r + 1'b1) : val_r;
  assign cnt_dec = count - 1'b1;

  assign stat.bad_radix = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
  assign stat.div_more = (iter != ITW'(DIV_STEPS - 1));
  assign stat.q_nonzero = (quotient != '0);
  assign stat.cnt_nonzero = (count != '0);

  // four restoring division steps on the top quotient bits
  always_comb begin
    logic [DIGIT_W:0]         t;
    logic [BITS_PER_STEP-1:0] qb;
    logic [DIGIT_W-1:0]       r;
    r = rem;
    qb = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r, quotient[QW-1-i]};
      if (t >= radix_r[DIGIT_W:0]) begin
        t = t - radix_r[DIGIT_W:0];
        qb[BITS_PER_STEP-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    q_next = {quotient[QW-BITS_PER_STEP-1:0], qb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient <= '0;
      count <= '0;
      neg <= 1'b0;
      iter <= '0;
    end else begin
      unique case (ctrl.op)
        OP_LOAD: begin
          if (!stat.bad_radix) begin
            neg <= neg_in;
            quotient <= QW'(mag);
            count <= '0;
            iter <= '0;
          end
        end
        OP_DIV: begin
          quotient <= q_next;
          iter <= iter + 1'b1;
        end
        OP_STORE: begin
          count <= count + 1'b1;
          iter <= '0;
        end
        OP_READ: begin
          if (count != '0) begin
            count <= cnt_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= value;
      radix_r <= radix;
    end
    if (ctrl.op == OP_LOAD) begin
      rem <= '0;
    end else if (ctrl.op == OP_DIV) begin
      rem <= rem_next;
    end else if (ctrl.op == OP_STORE) begin
      rem <= '0;
    end
  end

  // digit buffer, least significant digit first
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_STORE) begin
      digit_buffer[count[AW-1:0]] <= rem;
    end
    if (ctrl.op == OP_READ && count != '0) begin
      rdata <= digit_buffer[cnt_dec[AW-1:0]];
    end
  end

  always_comb begin
    unique case (ctrl.emit)
      EM_NONE: begin
        strobe = 1'b0;
        character = CH_NUL;
        last = 1'b0;
      end
      EM_SIGN: begin
        strobe = neg;
        character = CH_MINUS;
        last = 1'b0;
      end
      EM_DIGIT: begin
        strobe = 1'b1;
        character = digit_char(rdata);
        last = 1'b0;
      end
      EM_NUL: begin
        strobe = 1'b1;
        character = CH_NUL;
        last = 1'b1;
      end
      default: begin
        strobe = 1'b0;
        character = CH_NUL;
        last = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/integer_to_ascii_radix_unit.sv
// Converts one value to lowercase ASCII digits in bases 2 to 16, most significant digit
// first, then a NUL with last set; base 10 is signed and may lead with '-', a bad base gives
// only the NUL. Raise start while busy is low; results come on character/last marked by
// strobe for exactly one cycle each and cannot be held off, so the receiver must take them.
// Sequence: a bad base goes from the check step straight to the NUL; otherwise the divider
// retires four quotient bits a cycle, each digit takes a run of division steps over the
// whole quotient and then a store step, and then come the sign slot, the digits and the NUL.
// depends on itoa_pkg, itoa_seq, itoa_dp
module integer_to_ascii_radix_unit
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]            radix,
  output logic                          strobe,
  output logic [CHAR_W-1:0]             character,
  output logic                          last
);

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  assign busy = ctrl.busy;
  assign accept = start && !ctrl.busy;

  itoa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .value     (value),
    .radix     (radix),
    .ctrl      (ctrl),
    .stat      (stat),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

>>> hw/rtl/itoa_chk.sv
// port-level checks for the integer to ascii unit, bound to the top level
// depends on itoa_pkg and integer_to_ascii_radix_unit
module itoa_chk
  import itoa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] character,
  input logic              last
);

  // terminator carries NUL
  a_last_nul: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> character == CH_NUL)
    else $error("last item is not NUL");

  // other items are never NUL
  a_body_nonnul: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> character != CH_NUL)
    else $error("NUL before end of conversion");

  // an accepted item makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy after accept");

  // unit frees up right after the terminator
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("still busy after terminator");

  // no results while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !strobe)
    else $error("result while idle");

endmodule

bind integer_to_ascii_radix_unit itoa_chk u_itoa_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);
